// ===== hw/rtl/tinyjambu192_aead_encrypt_top_defines.svh =====
// Assertion macros used by the top-level RTL file of the TinyJAMBU-192 encryption block.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef TINYJAMBU192_AEAD_ENCRYPT_TOP_DEFINES_SVH
`define TINYJAMBU192_AEAD_ENCRYPT_TOP_DEFINES_SVH

`define TJ192_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tj192 implication check failed");

`define TJ192_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tj192 next-cycle check failed");

`endif

// ===== hw/rtl/tj192_pkg.sv =====
package tj192_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned KEY_W        = 64;
    localparam int unsigned CNT_W        = 3;
    localparam int unsigned KIND_W       = 3;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned FRAME_W      = 8;
    localparam int unsigned PC_W         = 5;
    localparam int unsigned GRP_W        = 6;
    localparam int unsigned KIDX_W       = 3;
    localparam int unsigned GROUPS_LONG  = 36;
    localparam int unsigned GROUPS_SHORT = 20;
    localparam int unsigned KEY_WORDS    = 6;

    localparam logic [KIND_W-1:0] KIND_START = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NONCE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_AD    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MSG   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FINAL = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd2;

    localparam logic [FRAME_W-1:0] FRAME_NONCE = 8'h10;
    localparam logic [FRAME_W-1:0] FRAME_AD    = 8'h30;
    localparam logic [FRAME_W-1:0] FRAME_MSG   = 8'h50;
    localparam logic [FRAME_W-1:0] FRAME_FINAL = 8'h70;
    localparam logic [FRAME_W-1:0] FRAME_NONE  = 8'h00;

    localparam logic [CNT_W-1:0] CNT_FULL = 3'd4;

    localparam logic [PC_W-1:0] PC_START = 5'd0;
    localparam logic [PC_W-1:0] PC_NONCE = 5'd2;
    localparam logic [PC_W-1:0] PC_AD    = 5'd5;
    localparam logic [PC_W-1:0] PC_MSG   = 5'd8;
    localparam logic [PC_W-1:0] PC_FINAL = 5'd12;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_FRAME  = 3'd1,
        OP_PERM   = 3'd2,
        OP_ABSORB = 3'd3,
        OP_EMIT   = 3'd4
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [FRAME_W-1:0] frame;
        logic               long_perm;
        logic               full;
        logic               tag;
        logic               last;
        logic               done;
    } t_cw;

    typedef struct packed {
        logic               clear;
        logic               frame_en;
        logic [FRAME_W-1:0] frame;
        logic               perm_en;
        logic [KIDX_W-1:0]  kidx;
        logic               absorb_en;
        logic               absorb_full;
    } t_dp_ctrl;

    function automatic t_cw make_cw(input t_op op, input logic [FRAME_W-1:0] frame,
                                    input logic long_perm, input logic full,
                                    input logic tag, input logic last, input logic done);
        t_cw cw;
        cw.op        = op;
        cw.frame     = frame;
        cw.long_perm = long_perm;
        cw.full      = full;
        cw.tag       = tag;
        cw.last      = last;
        cw.done      = done;
        return cw;
    endfunction

    // Microprogram: one control word per step.
    function automatic t_cw prog_rom(input logic [PC_W-1:0] pc);
        t_cw cw;
        unique case (pc)
            5'd0:    cw = make_cw(OP_CLEAR,  FRAME_NONE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            5'd1:    cw = make_cw(OP_PERM,   FRAME_NONE,  1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
            5'd2:    cw = make_cw(OP_FRAME,  FRAME_NONCE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            5'd3:    cw = make_cw(OP_PERM,   FRAME_NONE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            5'd4:    cw = make_cw(OP_ABSORB, FRAME_NONE,  1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
            5'd5:    cw = make_cw(OP_FRAME,  FRAME_AD,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            5'd6:    cw = make_cw(OP_PERM,   FRAME_NONE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            5'd7:    cw = make_cw(OP_ABSORB, FRAME_NONE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            5'd8:    cw = make_cw(OP_FRAME,  FRAME_MSG,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            5'd9:    cw = make_cw(OP_PERM,   FRAME_NONE,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            5'd10:   cw = make_cw(OP_EMIT,   FRAME_NONE,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
            5'd11:   cw = make_cw(OP_ABSORB, FRAME_NONE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            5'd12:   cw = make_cw(OP_FRAME,  FRAME_FINAL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            5'd13:   cw = make_cw(OP_PERM,   FRAME_NONE,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            5'd14:   cw = make_cw(OP_EMIT,   FRAME_NONE,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
            5'd15:   cw = make_cw(OP_FRAME,  FRAME_FINAL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            5'd16:   cw = make_cw(OP_PERM,   FRAME_NONE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            5'd17:   cw = make_cw(OP_EMIT,   FRAME_NONE,  1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
            default: cw = make_cw(OP_FRAME,  FRAME_NONE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        endcase
        return cw;
    endfunction

    function automatic logic [PC_W-1:0] kind_entry(input logic [KIND_W-1:0] kind);
        logic [PC_W-1:0] pc;
        unique case (kind)
            KIND_START: pc = PC_START;
            KIND_NONCE: pc = PC_NONCE;
            KIND_AD:    pc = PC_AD;
            KIND_MSG:   pc = PC_MSG;
            default:    pc = PC_FINAL;
        endcase
        return pc;
    endfunction

    function automatic logic [CNT_W-1:0] norm_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] res;
        res = ((cnt == 3'd0) || (cnt > CNT_FULL)) ? CNT_FULL : cnt;
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] byte_mask(input logic [CNT_W-1:0] cnt);
        logic [WORD_W-1:0] mask;
        unique case (cnt)
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
        return mask;
    endfunction

endpackage

// ===== hw/rtl/tj192_dp.sv =====
module tj192_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tj192_pkg::t_dp_ctrl                 i_ctrl,
    input  logic [tj192_pkg::KEY_W-1:0]         i_key_low,
    input  logic [tj192_pkg::KEY_W-1:0]         i_key_mid,
    input  logic [tj192_pkg::KEY_W-1:0]         i_key_high,
    input  logic [tj192_pkg::WORD_W-1:0]        i_word,
    input  logic [tj192_pkg::CNT_W-1:0]         i_cnt,
    output logic [tj192_pkg::WORD_W-1:0]        o_s2
);

    logic [tj192_pkg::WORD_W-1:0] r_s0, r_s1, r_s2, r_s3;
    logic [tj192_pkg::WORD_W-1:0] key_word;
    logic [tj192_pkg::WORD_W-1:0] t1, t2, t3, t4, upd;
    logic [tj192_pkg::WORD_W-1:0] abs_mask;

    always_comb begin
        unique case (i_ctrl.kidx)
            3'd0:    key_word = i_key_low[31:0];
            3'd1:    key_word = i_key_low[63:32];
            3'd2:    key_word = i_key_mid[31:0];
            3'd3:    key_word = i_key_mid[63:32];
            3'd4:    key_word = i_key_high[31:0];
            default: key_word = i_key_high[63:32];
        endcase
    end

    // One group of 32 rounds. The state rotates by one word per group, so the
    // word being updated always sits in r_s0.
    assign t1  = (r_s1 >> 15) | (r_s2 << 17);
    assign t2  = (r_s2 >> 6)  | (r_s3 << 26);
    assign t3  = (r_s2 >> 21) | (r_s3 << 11);
    assign t4  = (r_s2 >> 27) | (r_s3 << 5);
    assign upd = r_s0 ^ t1 ^ (~(t2 & t3)) ^ t4 ^ key_word;

    assign abs_mask = i_ctrl.absorb_full ? {tj192_pkg::WORD_W{1'b1}}
                                         : tj192_pkg::byte_mask(i_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (i_ctrl.clear) begin
            r_s0 <= '0;
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (i_ctrl.frame_en) begin
            r_s1 <= r_s1 ^ {{(tj192_pkg::WORD_W-tj192_pkg::FRAME_W){1'b0}}, i_ctrl.frame};
        end else if (i_ctrl.perm_en) begin
            r_s0 <= r_s1;
            r_s1 <= r_s2;
            r_s2 <= r_s3;
            r_s3 <= upd;
        end else if (i_ctrl.absorb_en) begin
            r_s3 <= r_s3 ^ (i_word & abs_mask);
            if (!i_ctrl.absorb_full && (i_cnt != tj192_pkg::CNT_FULL)) begin
                r_s1 <= r_s1 ^ {{(tj192_pkg::WORD_W-tj192_pkg::CNT_W){1'b0}}, i_cnt};
            end
        end
    end

    assign o_s2 = r_s2;

endmodule

// ===== hw/rtl/tinyjambu192_aead_encrypt_top.sv =====
// A message request yields one ciphertext word and a finalize request yields two tags.
// A new request is accepted only while the sequencer is idle; a stalled output
// holds the sequencer at its emit step. The round unit does one 32-round group a cycle.
// Reset is synchronous, active low: state and key registers clear to zero and the
// sequencer returns to idle.
`include "tinyjambu192_aead_encrypt_top_defines.svh"

module tinyjambu192_aead_encrypt_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tj192_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tj192_pkg::KEY_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [tj192_pkg::KIND_W-1:0]        i_kind,
    input  logic [tj192_pkg::WORD_W-1:0]        i_data_word,
    input  logic [tj192_pkg::CNT_W-1:0]         i_byte_count,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tj192_pkg::WORD_W-1:0]        o_out_word,
    output logic [tj192_pkg::CNT_W-1:0]         o_out_bytes,
    output logic                                o_out_is_tag,
    output logic                                o_out_last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_seq_state;

    localparam logic [tj192_pkg::GRP_W-1:0] GRP_LONG_LAST =
        tj192_pkg::GRP_W'(tj192_pkg::GROUPS_LONG - 1);
    localparam logic [tj192_pkg::GRP_W-1:0] GRP_SHORT_LAST =
        tj192_pkg::GRP_W'(tj192_pkg::GROUPS_SHORT - 1);
    localparam logic [tj192_pkg::KIDX_W-1:0] KIDX_LAST =
        tj192_pkg::KIDX_W'(tj192_pkg::KEY_WORDS - 1);

    logic [tj192_pkg::KEY_W-1:0]   r_key_low, r_key_mid, r_key_high;
    t_seq_state                    r_state, n_state;
    logic [tj192_pkg::PC_W-1:0]    r_pc, n_pc;
    logic [tj192_pkg::GRP_W-1:0]   r_grp, n_grp;
    logic [tj192_pkg::KIDX_W-1:0]  r_kidx, n_kidx;
    logic [tj192_pkg::WORD_W-1:0]  r_word;
    logic [tj192_pkg::CNT_W-1:0]   r_cnt;
    logic                          r_out_valid;
    logic [tj192_pkg::WORD_W-1:0]  r_out_word;
    logic [tj192_pkg::CNT_W-1:0]   r_out_bytes;
    logic                          r_out_is_tag;
    logic                          r_out_last;

    tj192_pkg::t_cw                cw;
    tj192_pkg::t_dp_ctrl           dp_ctrl;
    logic                          run;
    logic                          in_acc;
    logic                          grp_last;
    logic                          out_free;
    logic                          step_adv;
    logic                          emit_fire;
    logic [tj192_pkg::WORD_W-1:0]  s2;
    logic [tj192_pkg::WORD_W-1:0]  ct_word;

    assign run      = (r_state == ST_RUN);
    assign cw       = tj192_pkg::prog_rom(r_pc);
    assign in_acc   = i_in_valid && o_in_ready;
    assign grp_last = (r_grp == (cw.long_perm ? GRP_LONG_LAST : GRP_SHORT_LAST));
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (cw.op)
            tj192_pkg::OP_PERM: step_adv = grp_last;
            tj192_pkg::OP_EMIT: step_adv = out_free;
            default:            step_adv = 1'b1;
        endcase
    end

    assign emit_fire = run && (cw.op == tj192_pkg::OP_EMIT) && out_free;

    always_comb begin
        dp_ctrl.clear       = run && (cw.op == tj192_pkg::OP_CLEAR);
        dp_ctrl.frame_en    = run && (cw.op == tj192_pkg::OP_FRAME);
        dp_ctrl.frame       = cw.frame;
        dp_ctrl.perm_en     = run && (cw.op == tj192_pkg::OP_PERM);
        dp_ctrl.kidx        = r_kidx;
        dp_ctrl.absorb_en   = run && (cw.op == tj192_pkg::OP_ABSORB);
        dp_ctrl.absorb_full = cw.full;
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_grp   = r_grp;
        n_kidx  = r_kidx;
        if (in_acc && (i_kind <= tj192_pkg::KIND_FINAL)) begin
            n_state = ST_RUN;
            n_pc    = tj192_pkg::kind_entry(i_kind);
        end
        if (run) begin
            if (cw.op == tj192_pkg::OP_PERM) begin
                if (grp_last) begin
                    n_grp  = '0;
                    n_kidx = '0;
                end else begin
                    n_grp  = r_grp + 1'b1;
                    n_kidx = (r_kidx == KIDX_LAST) ? '0 : r_kidx + 1'b1;
                end
            end
            if (step_adv) begin
                if (cw.done) begin
                    n_state = ST_IDLE;
                    n_pc    = '0;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_grp   <= '0;
            r_kidx  <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_grp   <= n_grp;
            r_kidx  <= n_kidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_mid  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tj192_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                tj192_pkg::CFG_KEY_MID:  r_key_mid  <= i_cfg_data;
                tj192_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_word <= i_data_word;
            r_cnt  <= tj192_pkg::norm_count(i_byte_count);
        end
    end

    tj192_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (dp_ctrl),
        .i_key_low  (r_key_low),
        .i_key_mid  (r_key_mid),
        .i_key_high (r_key_high),
        .i_word     (r_word),
        .i_cnt      (r_cnt),
        .o_s2       (s2)
    );

    assign ct_word = (s2 ^ r_word) & tj192_pkg::byte_mask(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_word   <= cw.tag ? s2 : ct_word;
            r_out_bytes  <= cw.tag ? tj192_pkg::CNT_FULL : r_cnt;
            r_out_is_tag <= cw.tag;
            r_out_last   <= cw.last;
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_word   = r_out_word;
    assign o_out_bytes  = r_out_bytes;
    assign o_out_is_tag = r_out_is_tag;
    assign o_out_last   = r_out_last;

    `TJ192_ASSERT_NEXT(a_known_kind_runs, in_acc && (i_kind <= tj192_pkg::KIND_FINAL), r_state == ST_RUN)
    `TJ192_ASSERT_IMPL(a_idle_counters_clear, r_state == ST_IDLE, (r_grp == '0) && (r_kidx == '0))
    `TJ192_ASSERT_IMPL(a_ct_is_last, o_out_valid && !o_out_is_tag, o_out_last)

endmodule

// ===== test/tb_tinyjambu192_aead_encrypt_top.sv =====
`timescale 1ns / 100ps

module tb_tinyjambu192_aead_encrypt_top;

    localparam logic [tj192_pkg::KIND_W-1:0] KIND_RSVD_5 = 3'd5;
    localparam logic [tj192_pkg::KIND_W-1:0] KIND_RSVD_6 = 3'd6;
    localparam logic [tj192_pkg::KIND_W-1:0] KIND_RSVD_7 = 3'd7;

    localparam int unsigned DRAIN_CYCLES    = 80;
    localparam int unsigned ITEMS_PER_PHASE = 450;
    localparam int unsigned N_PHASES        = 4;
    localparam int unsigned N_DIRECTED      = 24;

    localparam int unsigned SEND_IDLE_PCT [N_PHASES]  = '{0, 62, 0, 8};
    localparam int unsigned RECV_STALL_PCT [N_PHASES] = '{0, 0, 62, 8};

    localparam logic [tj192_pkg::CFG_IDX_W-1:0] KEY_REG_IDX [3] = '{
        tj192_pkg::CFG_KEY_LOW, tj192_pkg::CFG_KEY_MID, tj192_pkg::CFG_KEY_HIGH
    };

    typedef struct packed {
        logic [tj192_pkg::KIND_W-1:0] kind;
        logic [tj192_pkg::WORD_W-1:0] word;
        logic [tj192_pkg::CNT_W-1:0]  cnt;
    } t_jambu_req;

    typedef struct packed {
        logic [tj192_pkg::WORD_W-1:0] word;
        logic [tj192_pkg::CNT_W-1:0]  nbytes;
        logic                         is_tag;
        logic                         last;
    } t_jambu_result;

    localparam t_jambu_req DIRECTED_REQS [N_DIRECTED] = '{
        '{tj192_pkg::KIND_START, 32'h0000_0000, tj192_pkg::CNT_FULL},
        '{tj192_pkg::KIND_NONCE, 32'h0000_0000, tj192_pkg::CNT_FULL},
        '{tj192_pkg::KIND_NONCE, 32'hFFFF_FFFF, 3'd0},
        '{tj192_pkg::KIND_NONCE, 32'h1234_5678, 3'd7},
        '{tj192_pkg::KIND_AD,    32'hFFFF_FFFF, tj192_pkg::CNT_FULL},
        '{tj192_pkg::KIND_AD,    32'hA5A5_A5A5, 3'd1},
        '{tj192_pkg::KIND_AD,    32'h5A5A_5A5A, 3'd2},
        '{tj192_pkg::KIND_AD,    32'hFFFF_FFFF, 3'd3},
        '{tj192_pkg::KIND_MSG,   32'h0000_0000, tj192_pkg::CNT_FULL},
        '{tj192_pkg::KIND_MSG,   32'hFFFF_FFFF, tj192_pkg::CNT_FULL},
        '{tj192_pkg::KIND_MSG,   32'hFFFF_FFFF, 3'd0},
        '{tj192_pkg::KIND_MSG,   32'h8000_0001, 3'd5},
        '{tj192_pkg::KIND_MSG,   32'hDEAD_BEEF, 3'd1},
        '{tj192_pkg::KIND_MSG,   32'hCAFE_F00D, 3'd2},
        '{tj192_pkg::KIND_MSG,   32'h0123_4567, 3'd3},
        '{KIND_RSVD_5,           32'hFFFF_FFFF, tj192_pkg::CNT_FULL},
        '{KIND_RSVD_6,           32'h0000_0000, 3'd6},
        '{KIND_RSVD_7,           32'hFFFF_FFFF, 3'd7},
        '{tj192_pkg::KIND_FINAL, 32'h0000_0000, tj192_pkg::CNT_FULL},
        '{tj192_pkg::KIND_FINAL, 32'hFFFF_FFFF, 3'd1},
        '{tj192_pkg::KIND_START, 32'hFFFF_FFFF, 3'd6},
        '{tj192_pkg::KIND_MSG,   32'h7654_3210, tj192_pkg::CNT_FULL},
        '{tj192_pkg::KIND_AD,    32'h0000_0000, 3'd0},
        '{tj192_pkg::KIND_FINAL, 32'h0000_0000, 3'd0}
    };

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [tj192_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [tj192_pkg::KEY_W-1:0]     i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [tj192_pkg::KIND_W-1:0]    i_kind;
    logic [tj192_pkg::WORD_W-1:0]    i_data_word;
    logic [tj192_pkg::CNT_W-1:0]     i_byte_count;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [tj192_pkg::WORD_W-1:0]    o_out_word;
    logic [tj192_pkg::CNT_W-1:0]     o_out_bytes;
    logic                            o_out_is_tag;
    logic                            o_out_last;

    logic [tj192_pkg::KEY_W-1:0]  model_key [3];
    logic [tj192_pkg::WORD_W-1:0] model_state [4];
    t_jambu_result                expected_results [$];
    int unsigned                  n_errors;
    int unsigned                  sent_items;
    int unsigned                  send_idle_pct;
    int unsigned                  recv_stall_pct;

    tinyjambu192_aead_encrypt_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word),
        .o_out_bytes  (o_out_bytes),
        .o_out_is_tag (o_out_is_tag),
        .o_out_last   (o_out_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [tj192_pkg::WORD_W-1:0] key_word_at(input int unsigned idx);
        logic [tj192_pkg::KEY_W-1:0] kreg;
        kreg = model_key[idx / 2];
        return (idx % 2 == 1) ? kreg[63:32] : kreg[31:0];
    endfunction

    // Each group of 32 rounds updates one state word; the key word index restarts per call.
    function automatic void run_rounds(input int unsigned groups);
        logic [tj192_pkg::WORD_W-1:0] a, b, c, t1, t2, t3, t4;
        int unsigned                  kidx;
        int unsigned                  w;
        kidx = 0;
        for (int unsigned g = 0; g < groups; g++) begin
            w  = g % 4;
            a  = model_state[(w + 1) % 4];
            b  = model_state[(w + 2) % 4];
            c  = model_state[(w + 3) % 4];
            t1 = (a >> 15) | (b << 17);
            t2 = (b >> 6) | (c << 26);
            t3 = (b >> 21) | (c << 11);
            t4 = (b >> 27) | (c << 5);
            model_state[w] ^= t1 ^ ~(t2 & t3) ^ t4 ^ key_word_at(kidx);
            kidx = (kidx == tj192_pkg::KEY_WORDS - 1) ? 0 : kidx + 1;
        end
    endfunction

    function automatic void predict_request(input t_jambu_req req);
        logic [tj192_pkg::CNT_W-1:0]  cnt;
        logic [tj192_pkg::WORD_W-1:0] mask;
        t_jambu_result                res;
        cnt  = (req.cnt == 3'd0 || req.cnt > tj192_pkg::CNT_FULL) ? tj192_pkg::CNT_FULL
                                                                  : req.cnt;
        mask = (cnt == tj192_pkg::CNT_FULL) ? '1 : (32'd1 << (8 * int'(cnt))) - 32'd1;
        case (req.kind)
            tj192_pkg::KIND_START: begin
                for (int i = 0; i < 4; i++) model_state[i] = '0;
                run_rounds(tj192_pkg::GROUPS_LONG);
            end
            tj192_pkg::KIND_NONCE: begin
                model_state[1] ^= 32'(tj192_pkg::FRAME_NONCE);
                run_rounds(tj192_pkg::GROUPS_SHORT);
                model_state[3] ^= req.word;
            end
            tj192_pkg::KIND_AD: begin
                model_state[1] ^= 32'(tj192_pkg::FRAME_AD);
                run_rounds(tj192_pkg::GROUPS_SHORT);
                model_state[3] ^= req.word & mask;
                if (cnt != tj192_pkg::CNT_FULL) model_state[1] ^= 32'(cnt);
            end
            tj192_pkg::KIND_MSG: begin
                model_state[1] ^= 32'(tj192_pkg::FRAME_MSG);
                run_rounds(tj192_pkg::GROUPS_LONG);
                model_state[3] ^= req.word & mask;
                res.word   = (model_state[2] ^ req.word) & mask;
                res.nbytes = cnt;
                res.is_tag = 1'b0;
                res.last   = 1'b1;
                expected_results.push_back(res);
                if (cnt != tj192_pkg::CNT_FULL) model_state[1] ^= 32'(cnt);
            end
            tj192_pkg::KIND_FINAL: begin
                model_state[1] ^= 32'(tj192_pkg::FRAME_FINAL);
                run_rounds(tj192_pkg::GROUPS_LONG);
                res.word   = model_state[2];
                res.nbytes = tj192_pkg::CNT_FULL;
                res.is_tag = 1'b1;
                res.last   = 1'b0;
                expected_results.push_back(res);
                model_state[1] ^= 32'(tj192_pkg::FRAME_FINAL);
                run_rounds(tj192_pkg::GROUPS_SHORT);
                res.word = model_state[2];
                res.last = 1'b1;
                expected_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic t_jambu_req make_req(input logic [tj192_pkg::KIND_W-1:0] kind,
                                            input logic [tj192_pkg::WORD_W-1:0] word,
                                            input logic [tj192_pkg::CNT_W-1:0] cnt);
        t_jambu_req req;
        req.kind = kind;
        req.word = word;
        req.cnt  = cnt;
        return req;
    endfunction

    // A count that means a full word, now and then written as an out-of-range value.
    function automatic logic [tj192_pkg::CNT_W-1:0] body_count();
        if ($urandom_range(9) != 0) return tj192_pkg::CNT_FULL;
        return ($urandom_range(1) == 0) ? 3'd0 : 3'($urandom_range(7, 5));
    endfunction

    function automatic logic [tj192_pkg::CNT_W-1:0] tail_count();
        if ($urandom_range(1) == 0) return 3'($urandom_range(3, 1));
        return body_count();
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_req(input t_jambu_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= req.kind;
        i_data_word  <= req.word;
        i_byte_count <= req.cnt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_request(req);
        if (req.kind <= tj192_pkg::KIND_FINAL) sent_items++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic load_key(input logic [tj192_pkg::KEY_W-1:0] lo,
                            input logic [tj192_pkg::KEY_W-1:0] mid,
                            input logic [tj192_pkg::KEY_W-1:0] hi);
        logic [tj192_pkg::KEY_W-1:0] vals [3];
        vals = '{lo, mid, hi};
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            i_cfg_index    <= KEY_REG_IDX[i];
            i_cfg_data     <= vals[i];
            model_key[i]    = vals[i];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_session();
        int unsigned n_ad;
        int unsigned n_msg;
        int unsigned n_noise;
        n_ad  = $urandom_range(4);
        n_msg = $urandom_range(6);
        if ($urandom_range(99) < 15) begin
            n_noise = $urandom_range(10, 2);
            repeat (n_noise) begin
                send_req(make_req(3'($urandom_range(7)), $urandom, 3'($urandom_range(7))));
            end
        end else begin
            send_req(make_req(tj192_pkg::KIND_START, $urandom, 3'($urandom_range(7))));
            repeat (3) begin
                send_req(make_req(tj192_pkg::KIND_NONCE, $urandom, 3'($urandom_range(7))));
            end
            for (int i = 0; i < n_ad; i++) begin
                send_req(make_req(tj192_pkg::KIND_AD, $urandom,
                                  (i == n_ad - 1) ? tail_count() : body_count()));
            end
            for (int i = 0; i < n_msg; i++) begin
                send_req(make_req(tj192_pkg::KIND_MSG, $urandom,
                                  (i == n_msg - 1) ? tail_count() : body_count()));
            end
            send_req(make_req(tj192_pkg::KIND_FINAL, $urandom, 3'($urandom_range(7))));
        end
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_jambu_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: out_word %h out_bytes %0d", o_out_word, o_out_bytes);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_word !== want.word) begin
                    $error("out_word: expected %h, actual %h", want.word, o_out_word);
                    n_errors++;
                end
                if (o_out_bytes !== want.nbytes) begin
                    $error("out_bytes: expected %0d, actual %0d", want.nbytes, o_out_bytes);
                    n_errors++;
                end
                if (o_out_is_tag !== want.is_tag) begin
                    $error("out_is_tag: expected %b, actual %b", want.is_tag, o_out_is_tag);
                    n_errors++;
                end
                if (o_out_last !== want.last) begin
                    $error("out_last: expected %b, actual %b", want.last, o_out_last);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = tj192_pkg::CFG_KEY_LOW;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_kind         = tj192_pkg::KIND_START;
        i_data_word    = '0;
        i_byte_count   = tj192_pkg::CNT_FULL;
        n_errors       = 0;
        sent_items     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 3; i++) model_key[i] = '0;
        for (int i = 0; i < 4; i++) model_state[i] = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) send_req(DIRECTED_REQS[i]);

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: load_key('1, '1, '1);
                1: load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
                2: load_key('0, '1, {$urandom, $urandom});
                default: load_key({$urandom, $urandom}, '0, {$urandom, $urandom});
            endcase
            send_idle_pct  = SEND_IDLE_PCT[p];
            recv_stall_pct = RECV_STALL_PCT[p];
            sent_items     = 0;
            while (sent_items < ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 4) wait_drained();
                send_session();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
